FILE: rtl/its_pkg.sv
// Shared types and constants for the interrupt timing statistics block.
`timescale 1ns / 1ps
package its_pkg;
    localparam int TickLimit = 10;
    localparam int CntW = $clog2(TickLimit + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    localparam logic [1:0] CFG_CORE   = 2'd0;
    localparam logic [1:0] CFG_TIMER  = 2'd1;
    localparam logic [1:0] CFG_BUDGET = 2'd2;

    localparam logic [3:0] Q_DCYC = 4'd0;
    localparam logic [3:0] Q_DNS  = 4'd1;
    // summary quantities, in the order they are sent
    localparam logic [3:0] Q_SAMPLES    = 4'd2;
    localparam logic [3:0] Q_OVERRUNS   = 4'd3;
    localparam logic [3:0] Q_TIMEOUTS   = 4'd4;
    localparam logic [3:0] Q_COMPLETE   = 4'd5;
    localparam logic [3:0] Q_MEAN_NS    = 4'd6;
    localparam logic [3:0] Q_MIN_NS     = 4'd7;
    localparam logic [3:0] Q_MAX_NS     = 4'd8;
    localparam logic [3:0] Q_JITTER_NS  = 4'd9;
    localparam logic [3:0] Q_MEAN_WIN   = 4'd10;
    localparam logic [3:0] Q_MEAN_EN    = 4'd11;
    localparam logic [3:0] Q_MEAN_DIS   = 4'd12;
    localparam logic [3:0] Q_MEAN_HND   = 4'd13;
    localparam logic [3:0] Q_MEAN_LAT   = 4'd14;
    localparam logic [3:0] Q_FIRST_SUMMARY = Q_SAMPLES;
    localparam logic [3:0] Q_LAST_SUMMARY  = Q_MEAN_LAT;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;
endpackage

FILE: rtl/interrupt_timing_statistics.sv
// Top level of the interrupt timing statistics block: sequencer and accumulators.
`timescale 1ns / 1ps
// Usage:
//   Configuration: i_cfg_valid/o_cfg_ready with index i_cfg_index and data
//   i_cfg_data; written only while idle. Index 0 core MHz, 1 timer MHz,
//   2 poll budget.
//   Input: one beat per command (clear, sample, finish) on i_valid/o_stall.
//   Output: result beats on o_valid/i_stall with o_last on the final beat.
//   Sequence: a clear is applied as it is accepted. A divider pass is a start
//   state and then a wait for the 32-step restoring divider. A later sample
//   runs an interval ns pass, two output beats, a latency ns pass and an
//   update state. The first sample has no interval and runs only the latency
//   ns pass and the update. A finish takes six divider passes and then 13
//   output beats. The one divider paces everything; no new input is taken
//   until the last result beat of the current command has been taken.
//   Reset: all accumulators cleared, min interval all ones, registers to
//   core 0, timer 0, budget 64.
//   Stall: a stalled result holds on the outputs, and the sequencer waits.
module interrupt_timing_statistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_entry_stamp,
    input  logic [15:0] i_latency_count,
    input  logic [31:0] i_trace_on_stamp,
    input  logic [31:0] i_window_end_stamp,
    input  logic [31:0] i_trace_off_stamp,
    input  logic [7:0]  i_enable_polls,
    input  logic [7:0]  i_disable_polls,
    input  logic        i_overrun_seen,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_quantity_code,
    output logic [3:0]  o_tick_index,
    output logic [31:0] o_value,
    output logic        o_last
);
    import its_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_NS, S_WAIT_NS, S_OUT_D, S_OUT_NS, S_DIV_LAT, S_WAIT_LAT,
        S_UPDATE, S_FIN_DIV, S_FIN_WAIT, S_FIN_OUT
    } t_state;

    t_state r_state;
    logic [9:0]  r_core, r_timer;
    logic [7:0]  r_budget;
    logic [CntW-1:0] r_n;
    logic [31:0] r_prev, r_ovr, r_tmo, r_min, r_max, r_isum;
    logic [31:0] r_wsum, r_esum, r_dsum, r_hsum, r_lsum;
    // captured sample
    logic [31:0] r_t0, r_t1, r_t2, r_t3, r_d, r_ns;
    logic [15:0] r_cnt;
    logic [7:0]  r_pon, r_poff;
    logic        r_ovf;
    // finish bookkeeping
    logic [2:0]  r_fdiv;
    logic [31:0] r_mean [6];
    logic [3:0]  r_fidx;
    logic        r_oval;
    logic [3:0]  r_oq, r_oti;
    logic [31:0] r_ov;
    logic        r_ol;

    t_div_req w_req;
    t_div_rsp w_rsp;

    its_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic w_in_acc, w_out_free, w_means_on, w_load;
    logic [31:0] w_core1, w_timer1, w_k, w_nn;
    assign w_in_acc = i_valid && !o_stall;
    assign w_out_free = !r_oval || !i_stall;
    // a new result beat goes into the output register this cycle
    assign w_load = w_out_free &&
                    (r_state == S_OUT_D || r_state == S_OUT_NS || r_state == S_FIN_OUT);
    assign o_stall = (r_state != S_IDLE) || r_oval;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_oval;
    assign w_core1 = (r_core == 10'd0) ? 32'd1 : {22'd0, r_core};
    assign w_timer1 = (r_timer == 10'd0) ? 32'd1 : {22'd0, r_timer};
    assign w_nn = 32'(r_n);
    assign w_k = w_nn - 32'd1;
    assign w_means_on = (r_core != 10'd0) && (r_n != '0);

    // divider request for each step
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_DIV_NS: begin
                w_req.start = 1'b1;
                w_req.dividend = r_d * 32'd1000;
                w_req.divisor = w_core1;
            end
            S_DIV_LAT: begin
                w_req.start = 1'b1;
                w_req.dividend = {16'd0, r_cnt} * 32'd1000;
                w_req.divisor = w_timer1;
            end
            S_FIN_DIV: begin
                w_req.start = 1'b1;
                w_req.divisor = (r_fdiv == 3'd0) ? ((w_k == 0) ? 32'd1 : w_k)
                              : ((w_nn == 0) ? 32'd1 : w_nn);
                case (r_fdiv)
                    3'd0: w_req.dividend = r_isum;
                    3'd1: w_req.dividend = r_wsum;
                    3'd2: w_req.dividend = r_esum;
                    3'd3: w_req.dividend = r_dsum;
                    3'd4: w_req.dividend = r_hsum;
                    default: w_req.dividend = r_lsum;
                endcase
            end
            default: w_req = '0;
        endcase
    end

    // summary value for a given quantity code
    function automatic logic [31:0] f_summary(input logic [3:0] q);
        logic [31:0] v;
        v = '0;
        case (q)
            Q_SAMPLES:   v = w_nn;
            Q_OVERRUNS:  v = r_ovr;
            Q_TIMEOUTS:  v = r_tmo;
            Q_COMPLETE:  v = (w_means_on && r_n == CntW'(TickLimit)) ? 32'd1 : 32'd0;
            Q_MEAN_NS:   v = (w_means_on && w_k != 0) ? r_mean[0] : 32'd0;
            Q_MIN_NS:    v = (w_means_on && w_k != 0) ? r_min : 32'd0;
            Q_MAX_NS:    v = (w_means_on && w_k != 0) ? r_max : 32'd0;
            Q_JITTER_NS: v = (w_means_on && w_k != 0) ? r_max - r_min : 32'd0;
            Q_MEAN_WIN:  v = w_means_on ? r_mean[1] : 32'd0;
            Q_MEAN_EN:   v = w_means_on ? r_mean[2] : 32'd0;
            Q_MEAN_DIS:  v = w_means_on ? r_mean[3] : 32'd0;
            Q_MEAN_HND:  v = w_means_on ? r_mean[4] : 32'd0;
            Q_MEAN_LAT:  v = w_means_on ? r_mean[5] : 32'd0;
            default: v = '0;
        endcase
        return v;
    endfunction

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval <= 1'b0;
            r_core <= '0; r_timer <= '0; r_budget <= 8'd64;
            r_n <= '0; r_prev <= '0; r_ovr <= '0; r_tmo <= '0;
            r_min <= '1; r_max <= '0; r_isum <= '0; r_wsum <= '0;
            r_esum <= '0; r_dsum <= '0; r_hsum <= '0; r_lsum <= '0;
            r_fdiv <= '0; r_fidx <= '0;
        end else begin
            if (r_oval && !i_stall && !w_load) r_oval <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CORE:   r_core <= i_cfg_data[9:0];
                    CFG_TIMER:  r_timer <= i_cfg_data[9:0];
                    CFG_BUDGET: r_budget <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_t0 <= i_entry_stamp; r_t1 <= i_trace_on_stamp;
                    r_t2 <= i_window_end_stamp; r_t3 <= i_trace_off_stamp;
                    r_cnt <= i_latency_count; r_pon <= i_enable_polls;
                    r_poff <= i_disable_polls; r_ovf <= i_overrun_seen;
                    r_d <= i_entry_stamp - r_prev;
                    unique case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            r_n <= '0; r_prev <= '0; r_ovr <= '0; r_tmo <= '0;
                            r_min <= '1; r_max <= '0; r_isum <= '0; r_wsum <= '0;
                            r_esum <= '0; r_dsum <= '0; r_hsum <= '0; r_lsum <= '0;
                        end
                        OP_SAMPLE: if (r_n != CntW'(TickLimit))
                            r_state <= (r_n != '0) ? S_DIV_NS : S_DIV_LAT;
                        OP_FINISH: begin
                            r_fdiv <= '0;
                            r_state <= S_FIN_DIV;
                        end
                        default: ;
                    endcase
                end
                S_DIV_NS: r_state <= S_WAIT_NS;
                S_WAIT_NS: if (w_rsp.done) begin
                    r_ns <= w_rsp.quotient;
                    r_state <= S_OUT_D;
                end
                S_OUT_D: if (w_out_free) begin
                    r_oval <= 1'b1; r_oq <= Q_DCYC; r_oti <= 4'(r_n);
                    r_ov <= r_d; r_ol <= 1'b0;
                    r_state <= S_OUT_NS;
                end
                S_OUT_NS: if (w_out_free) begin
                    r_oval <= 1'b1; r_oq <= Q_DNS; r_oti <= 4'(r_n);
                    r_ov <= r_ns; r_ol <= 1'b1;
                    if (r_ns < r_min) r_min <= r_ns;
                    if (r_ns > r_max) r_max <= r_ns;
                    r_isum <= r_isum + r_ns;
                    r_state <= S_DIV_LAT;
                end
                S_DIV_LAT: r_state <= S_WAIT_LAT;
                S_WAIT_LAT: if (w_rsp.done) begin
                    r_lsum <= r_lsum + w_rsp.quotient;
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_esum <= r_esum + (r_t1 - r_t0);
                    r_wsum <= r_wsum + (r_t2 - r_t1);
                    r_dsum <= r_dsum + (r_t3 - r_t2);
                    r_hsum <= r_hsum + (r_t3 - r_t0);
                    if (r_pon >= r_budget || r_poff >= r_budget) r_tmo <= r_tmo + 32'd1;
                    if (r_ovf) r_ovr <= r_ovr + 32'd1;
                    r_prev <= r_t0;
                    r_n <= r_n + CntW'(1);
                    r_state <= S_IDLE;
                end
                S_FIN_DIV: r_state <= S_FIN_WAIT;
                S_FIN_WAIT: if (w_rsp.done) begin
                    r_mean[r_fdiv] <= w_rsp.quotient;
                    if (r_fdiv == 3'd5) begin
                        r_fidx <= Q_FIRST_SUMMARY;
                        r_state <= S_FIN_OUT;
                    end else begin
                        r_fdiv <= r_fdiv + 3'd1;
                        r_state <= S_FIN_DIV;
                    end
                end
                S_FIN_OUT: if (w_out_free) begin
                    r_oval <= 1'b1; r_oq <= r_fidx; r_oti <= '0;
                    r_ov <= f_summary(r_fidx);
                    r_ol <= (r_fidx == Q_LAST_SUMMARY);
                    r_fidx <= r_fidx + 4'd1;
                    if (r_fidx == Q_LAST_SUMMARY) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_oval;
    assign o_quantity_code = r_oq;
    assign o_tick_index = r_oti;
    assign o_value = r_ov;
    assign o_last = r_ol;
endmodule

FILE: rtl/its_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module its_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  its_pkg::t_div_req i_req,
    output its_pkg::t_div_rsp o_rsp
);
    import its_pkg::*;

    logic [31:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_q[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_q = i_req.dividend; n_rem = '0; n_den = i_req.divisor;
            n_cnt = 6'd32; n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in the next dividend bit and try a subtract
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_q[31]};
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_q;
endmodule

FILE: rtl/its_checker.sv
// Port-level checker for the interrupt timing statistics block, with its bind.
`timescale 1ns / 1ps
module its_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_cfg_ready,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_quantity_code,
    input logic [3:0]  o_tick_index,
    input logic [31:0] o_value,
    input logic        o_last
);
    import its_pkg::*;

    // a result beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_quantity_code))
        else $error("stalled result changed");

    // no input is taken while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open with result pending");

    // summary items carry tick index zero
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quantity_code >= Q_FIRST_SUMMARY |-> o_tick_index == 4'd0)
        else $error("summary item with tick index");

    // the last flag marks the end of a run
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_quantity_code == Q_DNS || o_quantity_code == Q_LAST_SUMMARY))
        else $error("last on wrong quantity");

    // config only while idle
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_valid)
        else $error("config ready while busy");
endmodule

bind interrupt_timing_statistics its_checker u_its_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_cfg_ready(o_cfg_ready), .o_valid(o_valid), .i_stall(i_stall),
    .o_quantity_code(o_quantity_code), .o_tick_index(o_tick_index),
    .o_value(o_value), .o_last(o_last)
);

FILE: test/tb_interrupt_timing_statistics.sv
// Testbench for interrupt_timing_statistics: directed and random commands checked against a local predictor.
`timescale 1ns / 1ps

import its_pkg::*;

typedef struct {
    t_opcode     op;
    bit [31:0]   entry;
    bit [15:0]   lat;
    bit [31:0]   on_stamp;
    bit [31:0]   end_stamp;
    bit [31:0]   off_stamp;
    bit [7:0]    en_polls;
    bit [7:0]    dis_polls;
    bit          ovr;
} t_cmd_beat;

typedef struct {
    bit [3:0]  code;
    bit [3:0]  idx;
    bit [31:0] val;
    bit        last;
} t_stat_beat;

// Timing statistics predictor plus the queue of statistics still owed by the block
class timing_stats_board;
    bit [9:0]   core_mhz = 0;
    bit [9:0]   timer_mhz = 0;
    bit [7:0]   budget = 64;
    bit [3:0]   taken;
    bit [31:0]  prev_entry, ovr_tot, tmo_tot, min_ns, max_ns, ns_sum;
    bit [31:0]  win_sum, en_sum, dis_sum, hnd_sum, lat_sum;
    t_stat_beat owed[$];
    int         fails = 0;

    function new();
        clear_sums();
    endfunction

    function void clear_sums();
        taken = 0; prev_entry = 0; ovr_tot = 0; tmo_tot = 0;
        min_ns = 32'hFFFF_FFFF; max_ns = 0; ns_sum = 0;
        win_sum = 0; en_sum = 0; dis_sum = 0; hnd_sum = 0; lat_sum = 0;
    endfunction

    function void write_reg(bit [1:0] index, bit [31:0] data);
        case (index)
            CFG_CORE:   core_mhz = data[9:0];
            CFG_TIMER:  timer_mhz = data[9:0];
            CFG_BUDGET: budget = data[7:0];
            default: ;
        endcase
    endfunction

    function void push(bit [3:0] code, bit [3:0] idx, bit [31:0] val, bit last);
        t_stat_beat s;
        s.code = code; s.idx = idx; s.val = val; s.last = last;
        owed.push_back(s);
    endfunction

    // Note one accepted command beat and queue what it should produce
    function void note_command(t_cmd_beat c);
        bit [31:0] cyc, tim, d, ns, scaled, n, k;
        bit [31:0] v[13];
        cyc = (core_mhz != 0) ? {22'd0, core_mhz} : 32'd1;
        tim = (timer_mhz != 0) ? {22'd0, timer_mhz} : 32'd1;
        case (c.op)
            OP_CLEAR: clear_sums();
            OP_SAMPLE: begin
                if (taken < TickLimit) begin
                    if (taken != 0) begin
                        d = c.entry - prev_entry;
                        scaled = d * 32'd1000;
                        ns = scaled / cyc;
                        if (ns < min_ns) min_ns = ns;
                        if (ns > max_ns) max_ns = ns;
                        ns_sum += ns;
                        push(Q_DCYC, taken, d, 1'b0);
                        push(Q_DNS, taken, ns, 1'b1);
                    end
                    en_sum += c.on_stamp - c.entry;
                    win_sum += c.end_stamp - c.on_stamp;
                    dis_sum += c.off_stamp - c.end_stamp;
                    hnd_sum += c.off_stamp - c.entry;
                    scaled = {16'd0, c.lat} * 32'd1000;
                    lat_sum += scaled / tim;
                    if (c.en_polls >= budget || c.dis_polls >= budget) tmo_tot++;
                    if (c.ovr) ovr_tot++;
                    prev_entry = c.entry;
                    taken++;
                end
            end
            OP_FINISH: begin
                n = {28'd0, taken};
                foreach (v[i]) v[i] = 0;
                v[0] = n; v[1] = ovr_tot; v[2] = tmo_tot;
                if (core_mhz != 0 && n != 0) begin
                    k = n - 1;
                    v[3] = (n == TickLimit) ? 32'd1 : 32'd0;
                    if (k != 0) begin
                        v[4] = ns_sum / k;
                        v[5] = min_ns;
                        v[6] = max_ns;
                        v[7] = max_ns - min_ns;
                    end
                    v[8] = win_sum / n;
                    v[9] = en_sum / n;
                    v[10] = dis_sum / n;
                    v[11] = hnd_sum / n;
                    v[12] = lat_sum / n;
                end
                for (int i = 0; i < 13; i++)
                    push(4'(Q_FIRST_SUMMARY + i), 4'd0, v[i], i == 12);
            end
            default: ;
        endcase
    endfunction

    // Compare one result beat with the oldest owed statistic
    function void check_result(t_stat_beat got);
        t_stat_beat exp_s;
        if (owed.size() == 0) begin
            $error("unexpected result beat code %0d value %0h", got.code, got.val);
            fails++;
            return;
        end
        exp_s = owed.pop_front();
        if (got.code != exp_s.code) begin
            $error("quantity_code: expected %0d, got %0d", exp_s.code, got.code);
            fails++;
        end
        if (got.idx != exp_s.idx) begin
            $error("tick_index: expected %0d, got %0d", exp_s.idx, got.idx);
            fails++;
        end
        if (got.val != exp_s.val) begin
            $error("value: expected %0h, got %0h", exp_s.val, got.val);
            fails++;
        end
        if (got.last != exp_s.last) begin
            $error("last: expected %0d, got %0d", exp_s.last, got.last);
            fails++;
        end
    endfunction
endclass

module tb_interrupt_timing_statistics;
    localparam int IdleLimit = 4000;
    localparam int SettleCycles = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [31:0] i_entry_stamp;
    logic [15:0] i_latency_count;
    logic [31:0] i_trace_on_stamp;
    logic [31:0] i_window_end_stamp;
    logic [31:0] i_trace_off_stamp;
    logic [7:0]  i_enable_polls;
    logic [7:0]  i_disable_polls;
    logic        i_overrun_seen;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_quantity_code;
    logic [3:0]  o_tick_index;
    logic [31:0] o_value;
    logic        o_last;

    timing_stats_board board = new();
    int  idle_cycles = 0;
    bit  calm = 0;        // no idling on either side
    bit  hold_req = 0;    // ask the receiver for one long hold
    bit [31:0] stamp_base = 0;

    interrupt_timing_statistics dut (.*);

    // Clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Accepted beats go to the board; watchdog on lack of progress
    always @(posedge i_clk) begin
        t_cmd_beat  c;
        t_stat_beat r;
        bit         moved;
        if (i_rst_n) begin
            moved = 0;
            if (i_valid && !o_stall) begin
                c.op = t_opcode'(i_opcode);
                c.entry = i_entry_stamp;
                c.lat = i_latency_count;
                c.on_stamp = i_trace_on_stamp;
                c.end_stamp = i_window_end_stamp;
                c.off_stamp = i_trace_off_stamp;
                c.en_polls = i_enable_polls;
                c.dis_polls = i_disable_polls;
                c.ovr = i_overrun_seen;
                board.note_command(c);
                moved = 1;
            end
            if (o_valid && !i_stall) begin
                r.code = o_quantity_code;
                r.idx = o_tick_index;
                r.val = o_value;
                r.last = o_last;
                board.check_result(r);
                moved = 1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1;
            if (moved) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side back-pressure: random bursts and one long hold
    initial begin
        int burst;
        int hold;
        burst = 0;
        hold = 0;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold = 600;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_stall = 1;
            end else if (calm) begin
                i_stall = 0;
            end else if (burst > 0) begin
                burst--;
                i_stall = 1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16) - 1;
                i_stall = 1;
            end else begin
                i_stall = 0;
            end
        end
    end

    // One register write
    task automatic write_reg(bit [1:0] index, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = index;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // One command beat, with an optional random gap before it
    task automatic send_cmd(t_cmd_beat c);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid = 0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid = 1;
        i_opcode = c.op;
        i_entry_stamp = c.entry;
        i_latency_count = c.lat;
        i_trace_on_stamp = c.on_stamp;
        i_window_end_stamp = c.end_stamp;
        i_trace_off_stamp = c.off_stamp;
        i_enable_polls = c.en_polls;
        i_disable_polls = c.dis_polls;
        i_overrun_seen = c.ovr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_op(t_opcode op);
        t_cmd_beat c;
        c = '{op, $urandom, 16'($urandom), $urandom, $urandom, $urandom,
              8'($urandom), 8'($urandom), 1'($urandom)};
        send_cmd(c);
    endtask

    // A plausible interrupt sample: stamps move forward, polls near the budget
    task automatic send_sample();
        t_cmd_beat c;
        c.op = OP_SAMPLE;
        if ($urandom_range(0, 7) == 0) stamp_base = $urandom;
        else stamp_base = stamp_base + $urandom_range(1, 400000);
        c.entry = stamp_base;
        c.on_stamp = c.entry + $urandom_range(0, 500);
        c.end_stamp = c.on_stamp + $urandom_range(0, 5000);
        c.off_stamp = c.end_stamp + $urandom_range(0, 500);
        c.lat = 16'($urandom);
        c.en_polls = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
        c.dis_polls = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
        c.ovr = $urandom_range(0, 4) == 0;
        send_cmd(c);
    endtask

    // Wait for every owed result, then for any work that yields nothing
    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items);
        int sent;
        int cnt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                send_op(OP_CLEAR);
                cnt = $urandom_range(0, 12);
                repeat (cnt) send_sample();
                send_op(OP_FINISH);
                if ($urandom_range(0, 4) == 0) send_op(OP_FINISH);
                sent += cnt + 2;
            end else begin
                send_op(t_opcode'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    initial begin
        t_cmd_beat c;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_CORE;
        i_cfg_data = 0;
        i_valid = 0;
        i_opcode = OP_CLEAR;
        i_entry_stamp = 0;
        i_latency_count = 0;
        i_trace_on_stamp = 0;
        i_window_end_stamp = 0;
        i_trace_off_stamp = 0;
        i_enable_polls = 0;
        i_disable_polls = 0;
        i_overrun_seen = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: reset settings, finish with no samples, zero core clock
        send_op(OP_FINISH);
        c = '{OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0};
        send_cmd(c);
        send_op(OP_FINISH);
        c = '{OP_SAMPLE, '1, '1, '1, '1, '1, '1, '1, 1};
        send_cmd(c);
        send_op(OP_NONE);
        drain();
        write_reg(CFG_CORE, 32'd1023);
        write_reg(CFG_TIMER, 32'd1023);
        write_reg(CFG_BUDGET, 32'd255);
        // Single sample, then past the tick limit, repeated finish
        send_op(OP_CLEAR);
        send_sample();
        send_op(OP_FINISH);
        repeat (11) send_sample();
        send_op(OP_FINISH);
        send_op(OP_FINISH);
        drain();

        // Random phases over several settings
        write_reg(CFG_CORE, 32'd1);
        write_reg(CFG_TIMER, 32'd0);
        write_reg(CFG_BUDGET, 32'd1);
        write_reg(2'd3, $urandom);
        random_phase(50);
        drain();

        write_reg(CFG_CORE, 32'hFFFF_FC00 | 32'd200);
        write_reg(CFG_TIMER, 32'd1);
        write_reg(CFG_BUDGET, 32'd0);
        hold_req = 1;
        random_phase(50);
        drain();

        write_reg(CFG_CORE, 32'd0);
        write_reg(CFG_TIMER, 32'd100);
        write_reg(CFG_BUDGET, 32'd20);
        random_phase(50);
        drain();

        write_reg(CFG_CORE, $urandom);
        write_reg(CFG_TIMER, $urandom);
        write_reg(CFG_BUDGET, $urandom_range(1, 40));
        random_phase(60);
        drain();

        // Last part without idling
        calm = 1;
        write_reg(CFG_CORE, $urandom_range(1, 1023));
        write_reg(CFG_TIMER, $urandom_range(1, 1023));
        write_reg(CFG_BUDGET, $urandom_range(1, 255));
        random_phase(60);
        drain();

        if (board.owed.size() != 0) begin
            $error("%0d results never arrived", board.owed.size());
            board.fails++;
        end
        if (board.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
